[sv/bpli_pkg.sv]
// Package for the breakpoint interpolator: shared types, codes and constants.
package bpli_pkg;

  // Default table depth
  localparam int MaxPointsDef = 64;

  // Register indexes on the configuration port
  localparam logic RegMode = 1'b0;
  localparam logic RegPiu  = 1'b1;

  // Interpolation modes
  localparam logic [1:0] ModeLinear = 2'd0;
  localparam logic [1:0] ModeStepLo = 2'd1;
  localparam logic [1:0] ModeStepHi = 2'd2;

  // Item function codes
  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncQuery = 1'b1;

  // Reset values of the registers
  localparam logic [1:0] ModeReset = ModeLinear;
  localparam logic [6:0] PiuReset  = 7'd64;

  // Running search record handed from cell to cell
  typedef struct packed {
    logic signed [31:0] q;
    logic               lo_v;
    logic signed [31:0] lo_x;
    logic signed [31:0] lo_y;
    logic               lo2_v;
    logic signed [31:0] lo2_x;
    logic signed [31:0] lo2_y;
    logic               hi_v;
    logic signed [31:0] hi_x;
    logic signed [31:0] hi_y;
    logic               hi2_v;
    logic signed [31:0] hi2_x;
    logic signed [31:0] hi2_y;
    logic               lb_v;
    logic signed [31:0] lb_x;
    logic signed [31:0] lb_y;
    logic               ub_v;
    logic signed [31:0] ub_x;
    logic signed [31:0] ub_y;
  } rec_t;

endpackage

[sv/bpli_cell.sv]
// One breakpoint cell: holds an (x, y) entry and updates the passing search record.
module bpli_cell #(
  parameter int K  = 0,
  parameter int NW = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               we_i,
  input  logic signed [31:0] wx_i,
  input  logic signed [31:0] wy_i,
  input  logic [NW-1:0]      n_i,
  input  logic               vld_i,
  input  bpli_pkg::rec_t     rec_i,
  output logic               vld_o,
  output bpli_pkg::rec_t     rec_o
);

  logic signed [31:0] x_q, y_q;
  logic               vld_q;
  bpli_pkg::rec_t     rec_q, rec_d;
  logic               act;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      x_q <= wx_i;
      y_q <= wy_i;
    end
  end

  // Fold this entry into the record; lowest index wins on ties
  always_comb begin
    act   = (NW'(K) < n_i);
    rec_d = rec_i;
    if (act) begin
      // minimum and second minimum
      if (!rec_i.lo_v || x_q < rec_i.lo_x) begin
        rec_d.lo2_v = rec_i.lo_v;
        rec_d.lo2_x = rec_i.lo_x;
        rec_d.lo2_y = rec_i.lo_y;
        rec_d.lo_v  = 1'b1;
        rec_d.lo_x  = x_q;
        rec_d.lo_y  = y_q;
      end else if (!rec_i.lo2_v || x_q < rec_i.lo2_x) begin
        rec_d.lo2_v = 1'b1;
        rec_d.lo2_x = x_q;
        rec_d.lo2_y = y_q;
      end
      // maximum and second maximum
      if (!rec_i.hi_v || x_q > rec_i.hi_x) begin
        rec_d.hi2_v = rec_i.hi_v;
        rec_d.hi2_x = rec_i.hi_x;
        rec_d.hi2_y = rec_i.hi_y;
        rec_d.hi_v  = 1'b1;
        rec_d.hi_x  = x_q;
        rec_d.hi_y  = y_q;
      end else if (!rec_i.hi2_v || x_q > rec_i.hi2_x) begin
        rec_d.hi2_v = 1'b1;
        rec_d.hi2_x = x_q;
        rec_d.hi2_y = y_q;
      end
      // lower bound: largest x not above q
      if (x_q <= rec_i.q && (!rec_i.lb_v || x_q > rec_i.lb_x)) begin
        rec_d.lb_v = 1'b1;
        rec_d.lb_x = x_q;
        rec_d.lb_y = y_q;
      end
      // upper bound: smallest x not below q
      if (x_q >= rec_i.q && (!rec_i.ub_v || x_q < rec_i.ub_x)) begin
        rec_d.ub_v = 1'b1;
        rec_d.ub_x = x_q;
        rec_d.ub_y = y_q;
      end
    end
  end

  // Hand the record to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  // Record held until the next query passes
  always_ff @(posedge clk_i) begin
    if (vld_i) rec_q <= rec_d;
  end

  assign vld_o = vld_q;
  assign rec_o = rec_q;

endmodule

[sv/breakpoint_linear_interpolator.sv]
// Top level: breakpoint table as a chain of cells, with a serial multiply/divide back end.
// Load item: written to its cell when taken; in_ready_o stays high for the next item.
// Query: the cell chain, the select state, then for a linear result 33 multiply steps,
// 66 divide steps, the rounding state and the output state; step results go from select to
// output. One query in flight; no new item is taken until the output register is loaded.
// Reset clears control, mode (linear) and points_in_use (64); table entries are not cleared.
module breakpoint_linear_interpolator #(
  parameter int MAX_POINTS = bpli_pkg::MaxPointsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [5:0]         point_index_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] query_x_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] result_y_o,
  output logic               saturated_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int NW        = $clog2(MAX_POINTS + 1);
  localparam int MulSteps  = 33;
  localparam int DivSteps  = 66;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_SEL  = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_RND  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [1:0] mode_q;
  logic [6:0] piu_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= bpli_pkg::ModeReset;
      piu_q  <= bpli_pkg::PiuReset;
    end else if (cfg_we) begin
      if (paddr[2] == bpli_pkg::RegMode) mode_q <= pwdata[1:0];
      else                               piu_q  <= pwdata[6:0];
    end
  end

  assign prdata = (paddr[2] == bpli_pkg::RegPiu) ? {25'd0, piu_q} : {30'd0, mode_q};

  // Effective number of active entries
  logic [NW-1:0] n_eff;
  always_comb begin
    if (piu_q < 7'd2) n_eff = NW'(2);
    else if (int'(piu_q) > MAX_POINTS) n_eff = NW'(MAX_POINTS);
    else n_eff = NW'(piu_q);
  end

  // Input handshake
  logic in_acc, ld_acc, qry_acc;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign ld_acc     = in_acc & (func_i == bpli_pkg::FuncLoad);
  assign qry_acc    = in_acc & (func_i == bpli_pkg::FuncQuery);

  // Cell chain
  bpli_pkg::rec_t rec [MAX_POINTS+1];
  logic           vld [MAX_POINTS+1];
  bpli_pkg::rec_t rec_in;

  always_comb begin
    rec_in   = '0;
    rec_in.q = query_x_i;
  end
  assign rec[0] = rec_in;
  assign vld[0] = qry_acc;

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    bpli_cell #(.K(g), .NW(NW)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .we_i  (ld_acc && (int'(point_index_i) == g)),
      .wx_i  (point_x_i),
      .wy_i  (point_y_i),
      .n_i   (n_eff),
      .vld_i (vld[g]),
      .rec_i (rec[g]),
      .vld_o (vld[g+1]),
      .rec_o (rec[g+1])
    );
  end

  // Bracket selection from the finished record
  bpli_pkg::rec_t     r;
  logic signed [31:0] lbx, lby, ubx, uby, xa, ya, xb, yb;
  logic signed [32:0] dx, dy, den;
  logic               sel_direct, sel_neg;
  logic signed [31:0] sel_y;

  always_comb begin
    r   = rec[MAX_POINTS];
    lbx = r.lb_v ? r.lb_x : r.lo_x;
    lby = r.lb_v ? r.lb_y : r.lo_y;
    ubx = r.ub_v ? r.ub_x : r.hi_x;
    uby = r.ub_v ? r.ub_y : r.hi_y;
    if (r.q < r.lo_x) begin
      xa = r.lo_x;  ya = r.lo_y;  xb = r.lo2_x; yb = r.lo2_y;
    end else if (r.q > r.hi_x) begin
      xa = r.hi_x;  ya = r.hi_y;  xb = r.hi2_x; yb = r.hi2_y;
    end else begin
      xa = lbx;     ya = lby;     xb = ubx;     yb = uby;
    end
    dx  = {r.q[31], r.q} - {xa[31], xa};
    dy  = {yb[31], yb} - {ya[31], ya};
    den = {xb[31], xb} - {xa[31], xa};
    sel_neg = dx[32] ^ dy[32] ^ den[32];
    if (dx == 33'sd0 || dy == 33'sd0) sel_neg = 1'b0;
    case (mode_q)
      bpli_pkg::ModeStepLo: begin
        sel_direct = 1'b1;
        sel_y      = lby;
      end
      bpli_pkg::ModeStepHi: begin
        sel_direct = 1'b1;
        sel_y      = uby;
      end
      default: begin
        sel_direct = (xa == xb);
        sel_y      = ya;
      end
    endcase
  end

  // Arithmetic datapath registers
  logic [32:0]        mcand_q, mcand_d, den_q, den_d, rem_q, rem_d;
  logic [65:0]        prod_q, prod_d;
  logic               neg_q, neg_d;
  logic signed [31:0] ya_q, ya_d;
  logic [6:0]         cnt_q, cnt_d;
  logic signed [31:0] res_y_q, res_y_d;
  logic               res_sat_q, res_sat_d;

  // Serial steps and rounding
  logic [33:0]        mul_sum, div_trial;
  logic               div_ge, rnd_up;
  logic [66:0]        quo;
  logic signed [35:0] sum36;

  always_comb begin
    mul_sum   = {1'b0, prod_q[65:33]} + (prod_q[0] ? {1'b0, mcand_q} : 34'd0);
    div_trial = {rem_q, prod_q[65]};
    div_ge    = (div_trial >= {1'b0, den_q});
    rnd_up    = ({rem_q, 1'b0} >= {1'b0, den_q});
    quo       = {1'b0, prod_q} + {66'd0, rnd_up};
    if (neg_q) sum36 = {{4{ya_q[31]}}, ya_q} - {2'b00, quo[33:0]};
    else       sum36 = {{4{ya_q[31]}}, ya_q} + {2'b00, quo[33:0]};
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    mcand_d   = mcand_q;
    den_d     = den_q;
    rem_d     = rem_q;
    prod_d    = prod_q;
    neg_d     = neg_q;
    ya_d      = ya_q;
    cnt_d     = cnt_q;
    res_y_d   = res_y_q;
    res_sat_d = res_sat_q;
    unique case (state_q)
      S_IDLE: begin
        if (qry_acc) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (vld[MAX_POINTS]) state_d = S_SEL;
      end
      S_SEL: begin
        res_y_d   = sel_y;
        res_sat_d = 1'b0;
        ya_d      = ya;
        neg_d     = sel_neg;
        mcand_d   = dx[32] ? 33'(-dx) : 33'(dx);
        prod_d    = {33'd0, (dy[32] ? 33'(-dy) : 33'(dy))};
        den_d     = den[32] ? 33'(-den) : 33'(den);
        cnt_d     = '0;
        state_d   = sel_direct ? S_OUT : S_MUL;
      end
      S_MUL: begin
        prod_d = {mul_sum, prod_q[32:1]};
        cnt_d  = cnt_q + 7'd1;
        if (cnt_q == 7'(MulSteps - 1)) begin
          cnt_d   = '0;
          rem_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d  = div_ge ? 33'(div_trial - {1'b0, den_q}) : div_trial[32:0];
        prod_d = {prod_q[64:0], div_ge};
        cnt_d  = cnt_q + 7'd1;
        if (cnt_q == 7'(DivSteps - 1)) state_d = S_RND;
      end
      S_RND: begin
        if (quo[66:34] != 33'd0) begin
          res_sat_d = 1'b1;
          res_y_d   = neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else if (sum36[35:31] != {5{sum36[35]}}) begin
          res_sat_d = 1'b1;
          res_y_d   = sum36[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
          res_sat_d = 1'b0;
          res_y_d   = sum36[31:0];
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_o || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q   <= mcand_d;
    den_q     <= den_d;
    rem_q     <= rem_d;
    prod_q    <= prod_d;
    neg_q     <= neg_d;
    ya_q      <= ya_d;
    res_y_q   <= res_y_d;
    res_sat_q <= res_sat_d;
  end

  // Output register
  logic               out_valid_q;
  logic signed [31:0] out_y_q;
  logic               out_sat_q;
  logic               out_load;

  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_y_q   <= res_y_q;
      out_sat_q <= res_sat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_y_o  = out_y_q;
  assign saturated_o = out_sat_q;

endmodule

[tb/breakpoint_linear_interpolator_tb.sv]
// Testbench for the breakpoint linear interpolator: directed table, random items, predictor.
module breakpoint_linear_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumPoints   = 64;
  localparam int SettleCycles = 250;
  localparam int WatchLimit  = 6000;

  typedef enum logic [1:0] {RowLoad, RowQuery, RowCfg} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [5:0]  idx;   // table entry, or register index for a config row
    logic [31:0] a;     // point x, query x or register value
    logic [31:0] b;     // point y
    bit          typed; // expected result given in the row
    logic [31:0] ey;
    logic        es;
  } dir_row_t;

  typedef struct {
    logic signed [31:0] y;
    logic               sat;
  } interp_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               func_i = bpli_pkg::FuncLoad;
  logic [5:0]         point_index_i = '0;
  logic signed [31:0] point_x_i = '0;
  logic signed [31:0] point_y_i = '0;
  logic signed [31:0] query_x_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] result_y_o;
  logic               saturated_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  breakpoint_linear_interpolator dut (.*);

  always #4 clk_i = ~clk_i;

  // Shadow of the block state
  logic signed [31:0] shadow_x [NumPoints];
  logic signed [31:0] shadow_y [NumPoints];
  logic [1:0]         shadow_mode = bpli_pkg::ModeReset;
  logic [6:0]         shadow_piu = bpli_pkg::PiuReset;

  interp_result_t pending_results[$];
  int             mismatches = 0;
  int             snd_idle = 0;
  int             rcv_idle = 0;
  int             quiet_cycles = 0;
  dir_row_t       dir_rows[$];

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  // Lowest index holding the second smallest or second largest x, repeats counted
  function automatic int second_extreme_idx(input int n, input int ext, input bit want_max);
    longint v;
    bit     have;
    v = 0;
    have = 0;
    for (int k = 0; k < n; k++) begin
      if (k == ext) continue;
      if (!have || (want_max ? shadow_x[k] > v : shadow_x[k] < v)) begin
        v = shadow_x[k];
        have = 1;
      end
    end
    for (int k = 0; k < n; k++) if (shadow_x[k] == v) return k;
    return ext;
  endfunction

  // Exact line through entries a and b at q, rounded half away from zero, clipped
  function automatic interp_result_t line_value(input longint q, input int a, input int b);
    longint         dx, dy, den, r;
    logic [127:0]   p, d, quo, rem;
    bit             neg;
    interp_result_t res;
    dx  = q - longint'(shadow_x[a]);
    dy  = longint'(shadow_y[b]) - longint'(shadow_y[a]);
    den = longint'(shadow_x[b]) - longint'(shadow_x[a]);
    neg = ((dx < 0) != (dy < 0)) != (den < 0);
    if (dx == 0 || dy == 0) neg = 0;
    p   = 128'(dx < 0 ? -dx : dx) * 128'(dy < 0 ? -dy : dy);
    d   = 128'(den < 0 ? -den : den);
    quo = p / d;
    rem = p % d;
    if (rem >= d - rem) quo++;
    res.sat = 1'b0;
    if (quo > 128'h3_FFFF_FFFF) begin
      res.sat = 1'b1;
      res.y = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      return res;
    end
    r = neg ? longint'(shadow_y[a]) - longint'(quo[63:0])
            : longint'(shadow_y[a]) + longint'(quo[63:0]);
    if (r > 64'sd2147483647) begin
      res.sat = 1'b1;
      res.y = 32'sh7FFF_FFFF;
    end else if (r < -64'sd2147483648) begin
      res.sat = 1'b1;
      res.y = 32'sh8000_0000;
    end else begin
      res.y = r[31:0];
    end
    return res;
  endfunction

  function automatic interp_result_t predict_query(input logic signed [31:0] qx);
    int             n, lo, hi, lb, ub, a, b;
    longint         q;
    interp_result_t res;
    q = qx;
    n = shadow_piu;
    if (n < 2) n = 2;
    if (n > NumPoints) n = NumPoints;
    lo = 0;
    hi = 0;
    for (int k = 1; k < n; k++) begin
      if (shadow_x[k] < shadow_x[lo]) lo = k;
      if (shadow_x[k] > shadow_x[hi]) hi = k;
    end
    lb = lo;
    for (int k = 0; k < n; k++)
      if (shadow_x[lb] < shadow_x[k] && shadow_x[k] <= q) lb = k;
    ub = hi;
    for (int k = 0; k < n; k++)
      if (q <= shadow_x[k] && shadow_x[k] < shadow_x[ub]) ub = k;
    res.sat = 1'b0;
    if (shadow_mode == bpli_pkg::ModeStepLo) begin
      res.y = shadow_y[lb];
    end else if (shadow_mode == bpli_pkg::ModeStepHi) begin
      res.y = shadow_y[ub];
    end else begin
      // linear, mode three included
      if (q < shadow_x[lo]) begin
        a = lo;
        b = second_extreme_idx(n, lo, 1'b0);
      end else if (q > shadow_x[hi]) begin
        a = hi;
        b = second_extreme_idx(n, hi, 1'b1);
      end else begin
        a = lb;
        b = ub;
      end
      if (a == b) res.y = shadow_y[a];
      else res = line_value(q, a, b);
    end
    return res;
  endfunction

  // Send one item; entered and left at a rising edge, valid left high
  task automatic send_item(input logic func, input logic [5:0] idx, input logic [31:0] px,
                           input logic [31:0] py, input logic [31:0] qx,
                           input bit typed, input logic [31:0] ey, input logic es);
    interp_result_t exp_res;
    if ($urandom_range(0, 99) < snd_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < snd_idle);
    end
    in_valid_i    <= 1'b1;
    func_i        <= func;
    point_index_i <= idx;
    point_x_i     <= px;
    point_y_i     <= py;
    query_x_i     <= qx;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    if (func == bpli_pkg::FuncLoad) begin
      shadow_x[idx] = px;
      shadow_y[idx] = py;
    end else begin
      exp_res = predict_query(qx);
      if (typed) begin
        if (exp_res.y !== ey || exp_res.sat !== es)
          report_mismatch($sformatf("predictor disagrees with table row, q=%h", qx));
        exp_res.y = ey;
        exp_res.sat = es;
      end
      pending_results = {pending_results, exp_res};
    end
  endtask

  // Hold off until every result is back and the block has gone quiet
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register write: setup then access phase, then read back
  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] exp_rd;
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == bpli_pkg::RegMode) begin
      shadow_mode = value[1:0];
      exp_rd = {30'd0, value[1:0]};
    end else begin
      shadow_piu = value[6:0];
      exp_rd = {25'd0, value[6:0]};
    end
    @(negedge clk_i);
    if (prdata !== exp_rd || pready !== 1'b1)
      report_mismatch($sformatf("register %0d reads %h, expected %h", idx, prdata, exp_rd));
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord(input bit narrow);
    if (narrow) return (32'($urandom_range(0, 15)) - 32'd8) << 16;
    return $urandom;
  endfunction

  // Result sink: ready at random, check at the falling edge before acceptance
  always @(posedge clk_i) out_ready_i <= ($urandom_range(0, 99) >= rcv_idle);

  always @(negedge clk_i) begin
    interp_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result y=%h", result_y_o));
      end else begin
        exp_res = pending_results.pop_front();
        if (result_y_o !== exp_res.y)
          report_mismatch($sformatf("result_y %h, expected %h", result_y_o, exp_res.y));
        if (saturated_o !== exp_res.sat)
          report_mismatch($sformatf("saturated %b, expected %b", saturated_o, exp_res.sat));
      end
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(negedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchLimit) begin
      $display("breakpoint_linear_interpolator regression: fail");
      $finish;
    end
  end

  function automatic dir_row_t mk_row(input row_kind_e kind, input logic [5:0] idx,
                                      input logic [31:0] a, input logic [31:0] b,
                                      input bit typed, input logic [31:0] ey, input logic es);
    dir_row_t r;
    r = '{kind, idx, a, b, typed, ey, es};
    return r;
  endfunction

  // Append one row to the directed table
  task automatic add_row(input row_kind_e kind, input logic [5:0] idx,
                         input logic [31:0] a, input logic [31:0] b,
                         input bit typed, input logic [31:0] ey, input logic es);
    dir_rows = {dir_rows, mk_row(kind, idx, a, b, typed, ey, es)};
  endtask

  initial begin
    int          n_act;
    bit          narrow;
    logic [5:0]  idx;
    logic [31:0] qx;
    logic [6:0]  piu_pick [8];

    piu_pick = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd64, 7'd65, 7'd127, 7'd10};

    // Directed table; table holds y = 2x at x = k after the fill below
    add_row(RowQuery, 0, 32'h0003_0000, 0, 1, 32'h0006_0000, 0);
    add_row(RowQuery, 0, 32'h8000_0000, 0, 1, 32'h8000_0000, 1);
    add_row(RowQuery, 0, 32'h7FFF_FFFF, 0, 1, 32'h7FFF_FFFF, 1);
    add_row(RowQuery, 0, 32'h0002_8000, 0, 1, 32'h0005_0000, 0);
    // duplicate x: the lower index wins
    add_row(RowLoad, 5, 32'h0003_0000, 32'h1234_5678, 0, 0, 0);
    add_row(RowQuery, 0, 32'h0003_0000, 0, 1, 32'h0006_0000, 0);
    add_row(RowCfg, bpli_pkg::RegMode, bpli_pkg::ModeStepLo, 0, 0, 0, 0);
    add_row(RowQuery, 0, 32'h0002_8000, 0, 1, 32'h0004_0000, 0);
    add_row(RowCfg, bpli_pkg::RegMode, bpli_pkg::ModeStepHi, 0, 0, 0, 0);
    add_row(RowQuery, 0, 32'h0002_8000, 0, 1, 32'h0006_0000, 0);
    add_row(RowCfg, bpli_pkg::RegMode, 3, 0, 0, 0, 0);
    add_row(RowQuery, 0, 32'h0002_8000, 0, 1, 32'h0005_0000, 0);
    // extreme field values in the table
    add_row(RowLoad, 63, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
    add_row(RowLoad, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
    add_row(RowCfg, bpli_pkg::RegMode, bpli_pkg::ModeLinear, 0, 0, 0, 0);
    add_row(RowQuery, 0, 32'h0000_0000, 0, 0, 0, 0);
    add_row(RowQuery, 0, 32'h7FFF_0000, 0, 0, 0, 0);
    add_row(RowCfg, bpli_pkg::RegPiu, 0, 0, 0, 0, 0);
    add_row(RowQuery, 0, 32'h0001_0000, 0, 0, 0, 0);
    add_row(RowCfg, bpli_pkg::RegPiu, 127, 0, 0, 0, 0);
    add_row(RowQuery, 0, 32'hFFFF_0000, 0, 0, 0, 0);
    add_row(RowCfg, bpli_pkg::RegPiu, 2, 0, 0, 0, 0);
    add_row(RowQuery, 0, 32'h8000_0000, 0, 0, 0, 0);
    add_row(RowCfg, bpli_pkg::RegPiu, 64, 0, 0, 0, 0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every entry so no query touches an unwritten one
    for (int k = 0; k < NumPoints; k++)
      send_item(bpli_pkg::FuncLoad, k[5:0], 32'(k) << 16, 32'(k) << 17, 0, 0, 0, 0);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        RowLoad: send_item(bpli_pkg::FuncLoad, dir_rows[i].idx, dir_rows[i].a,
                           dir_rows[i].b, 0, 0, 0, 0);
        RowQuery: send_item(bpli_pkg::FuncQuery, 0, 0, 0, dir_rows[i].a, dir_rows[i].typed,
                            dir_rows[i].ey, dir_rows[i].es);
        default: write_reg(dir_rows[i].idx[0], dir_rows[i].a);
      endcase
    end

    // Random part: three idling phases, five settings each
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 26 : (ph == 1) ? 67 : 0;
      rcv_idle = (ph == 0) ? 67 : (ph == 1) ? 26 : 0;
      for (int bt = 0; bt < 5; bt++) begin
        write_reg(bpli_pkg::RegMode, $urandom_range(0, 3));
        write_reg(bpli_pkg::RegPiu, piu_pick[$urandom_range(0, 7)] == 7'd10 ?
                  $urandom_range(0, 127) : piu_pick[$urandom_range(0, 7)]);
        narrow = $urandom_range(0, 1);
        n_act = shadow_piu < 2 ? 2 : shadow_piu > NumPoints ? NumPoints : shadow_piu;
        for (int it = 0; it < 100; it++) begin
          if ($urandom_range(0, 99) < 30) begin
            idx = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(0, n_act - 1));
            send_item(bpli_pkg::FuncLoad, idx, rand_coord(narrow),
                      rand_coord($urandom_range(0, 1)), $urandom, 0, 0, 0);
          end else begin
            case ($urandom_range(0, 2))
              0: qx = $urandom;
              1: qx = shadow_x[$urandom_range(0, n_act - 1)] +
                      32'($urandom_range(0, 4)) - 32'd2;
              default: qx = rand_coord(1'b1) + 32'($urandom_range(0, 65535));
            endcase
            send_item(bpli_pkg::FuncQuery, 6'($urandom), $urandom, $urandom, qx, 0, 0, 0);
          end
        end
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("breakpoint_linear_interpolator regression: pass");
    end else begin
      $display("breakpoint_linear_interpolator regression: fail");
    end
    $finish;
  end

endmodule
